@@ design/cbct_pkg.sv @@
// ----------------------------------------------------------------------------
// Color blob centroid tracker package
// Shared widths, move codes and the command bundle between control and datapath.
// ----------------------------------------------------------------------------
package cbct_pkg;

    localparam int COORD_BITS = 10;
    localparam int CHAN_BITS  = 8;
    localparam int SUM_BITS   = 3 * COORD_BITS;
    localparam int COUNT_BITS = 2 * COORD_BITS + 1;
    localparam int STEP_BITS  = $clog2(SUM_BITS);
    localparam int CFG_BITS   = (COORD_BITS > CHAN_BITS) ? COORD_BITS : CHAN_BITS;
    localparam int IDX_BITS   = 3;
    localparam int MOVE_BITS  = 3;

    localparam int IN_RAW   = 3 * CHAN_BITS + 2 * COORD_BITS;
    localparam int IN_BITS  = ((IN_RAW + 7) / 8) * 8;
    localparam int OUT_RAW  = 3 * CHAN_BITS + 2 * COORD_BITS + MOVE_BITS;
    localparam int OUT_BITS = ((OUT_RAW + 7) / 8) * 8;

    // Configuration register indexes.
    localparam logic [IDX_BITS-1:0] REG_HUE_REF  = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_SAT_REF  = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_VAL_REF  = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_HUE_TOL  = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_SAT_TOL  = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_VAL_TOL  = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_CENTER_X = 3'd6;
    localparam logic [IDX_BITS-1:0] REG_CENTER_Y = 3'd7;

    // Pan and tilt move codes.
    localparam logic [MOVE_BITS-1:0] MV_NONE       = 3'd0;
    localparam logic [MOVE_BITS-1:0] MV_DOWN_RIGHT = 3'd1;
    localparam logic [MOVE_BITS-1:0] MV_UP_RIGHT   = 3'd2;
    localparam logic [MOVE_BITS-1:0] MV_DOWN_LEFT  = 3'd3;
    localparam logic [MOVE_BITS-1:0] MV_UP_LEFT    = 3'd4;

    typedef struct packed {
        logic load_pix;    // ordinary pixel transfer: register its result
        logic capture;     // frame-end transfer: accumulate and start the divide
        logic step;        // one restoring-division step
        logic load_frame;  // register the frame-end result
    } t_cmd;

endpackage

@@ design/cbct_ctrl.sv @@
// ----------------------------------------------------------------------------
// Color blob centroid tracker controller
// Sequences pixel transfers, the bit-serial centroid divide and the output slot.
// ----------------------------------------------------------------------------
module cbct_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    input  logic          i_out_ready,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output cbct_pkg::t_cmd o_cmd
);
    import cbct_pkg::*;

    typedef enum logic [2:0] {
        S_RUN = 3'b001,
        S_DIV = 3'b010,
        S_FIN = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [STEP_BITS-1:0] r_step, n_step;
    logic                 r_out_valid, n_out_valid;
    logic                 slot_free;
    logic                 accept;
    t_cmd                 cmd;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_RUN) && slot_free;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        cmd            = '0;
        cmd.load_pix   = accept && !i_in_last;
        cmd.capture    = accept && i_in_last;
        cmd.step       = (r_state == S_DIV);
        cmd.load_frame = (r_state == S_FIN) && slot_free;
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_RUN: begin
                if (cmd.capture) begin
                    n_state = S_DIV;
                    n_step  = '0;
                end
            end
            S_DIV: begin
                if (r_step == STEP_BITS'(SUM_BITS - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_FIN: begin
                if (cmd.load_frame) begin
                    n_state = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_comb begin
        if (cmd.load_pix || cmd.load_frame) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // A frame end always runs the full divide before anything else is taken.
    a_capture_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |=> (r_state == S_DIV) && (r_step == '0))
        else $error("frame end did not start the divide at step zero");

    a_no_input_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_RUN) |-> !o_in_ready)
        else $error("input ready while the divide is busy");

    a_result_not_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("pending result lost without a transfer");

    a_frame_load_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_frame |-> (r_state == S_FIN) && slot_free)
        else $error("frame result loaded over a pending result");

endmodule

@@ design/cbct_dp.sv @@
// ----------------------------------------------------------------------------
// Color blob centroid tracker datapath
// Config registers, color window match, saturating sums, divider and output.
// ----------------------------------------------------------------------------
module cbct_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cbct_pkg::IDX_BITS-1:0]   i_cfg_idx,
    input  logic [cbct_pkg::CFG_BITS-1:0]   i_cfg_data,
    input  logic [cbct_pkg::IN_BITS-1:0]    i_pix,
    input  cbct_pkg::t_cmd                  i_cmd,
    output logic [cbct_pkg::OUT_BITS-1:0]   o_data,
    output logic                            o_matched,
    output logic                            o_frame_done
);
    import cbct_pkg::*;

    logic [CHAN_BITS-1:0]  r_hue_ref, r_sat_ref, r_val_ref;
    logic [CHAN_BITS-1:0]  r_hue_tol, r_sat_tol, r_val_tol;
    logic [COORD_BITS-1:0] r_center_x, r_center_y;

    logic [CHAN_BITS-1:0]  pix_hue, pix_sat, pix_val;
    logic [COORD_BITS-1:0] pix_row, pix_col;
    logic                  hit;

    logic [SUM_BITS-1:0]   r_row_sum, r_col_sum;
    logic [COUNT_BITS-1:0] r_count;
    logic [SUM_BITS-1:0]   row_sum_upd, col_sum_upd;
    logic [COUNT_BITS-1:0] count_upd;
    logic [SUM_BITS:0]     row_add, col_add;
    logic [COUNT_BITS:0]   count_add;

    logic [SUM_BITS-1:0]   r_qx, r_qy;
    logic [COUNT_BITS-1:0] r_rx, r_ry, r_den;
    logic [COUNT_BITS:0]   trial_x, trial_y;
    logic                  ge_x, ge_y;
    logic [COORD_BITS-1:0] cen_x, cen_y;
    logic [MOVE_BITS-1:0]  move;

    logic                  r_pend_hit;
    logic [CHAN_BITS-1:0]  r_pend_hue, r_pend_sat, r_pend_val;

    logic [CHAN_BITS-1:0]  r_o_hue, r_o_sat, r_o_val;
    logic [COORD_BITS-1:0] r_o_cx, r_o_cy;
    logic [MOVE_BITS-1:0]  r_o_move;
    logic                  r_o_matched, r_o_done;

    function automatic logic in_window(input logic [CHAN_BITS-1:0] p,
                                       input logic [CHAN_BITS-1:0] r,
                                       input logic [CHAN_BITS-1:0] t);
        logic [CHAN_BITS:0] pt;
        logic [CHAN_BITS:0] rt;
        pt = {1'b0, p} + {1'b0, t};
        rt = {1'b0, r} + {1'b0, t};
        // Same as r - t <= p <= r + t in signed arithmetic, without wrap.
        return (pt >= {1'b0, r}) && ({1'b0, p} <= rt);
    endfunction

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_ref  <= '0;
            r_sat_ref  <= '0;
            r_val_ref  <= '0;
            r_hue_tol  <= CHAN_BITS'(20);
            r_sat_tol  <= CHAN_BITS'(50);
            r_val_tol  <= CHAN_BITS'(50);
            r_center_x <= COORD_BITS'(160);
            r_center_y <= COORD_BITS'(120);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HUE_REF:  r_hue_ref  <= i_cfg_data[CHAN_BITS-1:0];
                REG_SAT_REF:  r_sat_ref  <= i_cfg_data[CHAN_BITS-1:0];
                REG_VAL_REF:  r_val_ref  <= i_cfg_data[CHAN_BITS-1:0];
                REG_HUE_TOL:  r_hue_tol  <= i_cfg_data[CHAN_BITS-1:0];
                REG_SAT_TOL:  r_sat_tol  <= i_cfg_data[CHAN_BITS-1:0];
                REG_VAL_TOL:  r_val_tol  <= i_cfg_data[CHAN_BITS-1:0];
                REG_CENTER_X: r_center_x <= i_cfg_data[COORD_BITS-1:0];
                REG_CENTER_Y: r_center_y <= i_cfg_data[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign pix_hue = i_pix[CHAN_BITS-1:0];
    assign pix_sat = i_pix[2*CHAN_BITS-1:CHAN_BITS];
    assign pix_val = i_pix[3*CHAN_BITS-1:2*CHAN_BITS];
    assign pix_row = i_pix[3*CHAN_BITS+COORD_BITS-1:3*CHAN_BITS];
    assign pix_col = i_pix[3*CHAN_BITS+2*COORD_BITS-1:3*CHAN_BITS+COORD_BITS];

    assign hit = in_window(pix_hue, r_hue_ref, r_hue_tol) &&
                 in_window(pix_sat, r_sat_ref, r_sat_tol) &&
                 in_window(pix_val, r_val_ref, r_val_tol);

    // Saturating accumulation; the carry out selects the all-ones value.
    assign row_add   = {1'b0, r_row_sum} + (SUM_BITS + 1)'(pix_row);
    assign col_add   = {1'b0, r_col_sum} + (SUM_BITS + 1)'(pix_col);
    assign count_add = {1'b0, r_count} + (COUNT_BITS + 1)'(1);

    always_comb begin
        row_sum_upd = r_row_sum;
        col_sum_upd = r_col_sum;
        count_upd   = r_count;
        if (hit) begin
            row_sum_upd = row_add[SUM_BITS] ? '1 : row_add[SUM_BITS-1:0];
            col_sum_upd = col_add[SUM_BITS] ? '1 : col_add[SUM_BITS-1:0];
            count_upd   = count_add[COUNT_BITS] ? '1 : count_add[COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_sum <= '0;
            r_col_sum <= '0;
            r_count   <= COUNT_BITS'(1);
        end else if (i_cmd.capture) begin
            r_row_sum <= '0;
            r_col_sum <= '0;
            r_count   <= COUNT_BITS'(1);
        end else if (i_cmd.load_pix) begin
            r_row_sum <= row_sum_upd;
            r_col_sum <= col_sum_upd;
            r_count   <= count_upd;
        end
    end

    // Restoring divider, one quotient bit per step for both axes.
    assign trial_x = {r_rx, r_qx[SUM_BITS-1]};
    assign trial_y = {r_ry, r_qy[SUM_BITS-1]};
    assign ge_x    = trial_x >= {1'b0, r_den};
    assign ge_y    = trial_y >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_qx       <= col_sum_upd;
            r_qy       <= row_sum_upd;
            r_den      <= count_upd;
            r_rx       <= '0;
            r_ry       <= '0;
            r_pend_hit <= hit;
            r_pend_hue <= pix_hue;
            r_pend_sat <= pix_sat;
            r_pend_val <= pix_val;
        end else if (i_cmd.step) begin
            r_qx <= {r_qx[SUM_BITS-2:0], ge_x};
            r_qy <= {r_qy[SUM_BITS-2:0], ge_y};
            r_rx <= ge_x ? COUNT_BITS'(trial_x - {1'b0, r_den}) : trial_x[COUNT_BITS-1:0];
            r_ry <= ge_y ? COUNT_BITS'(trial_y - {1'b0, r_den}) : trial_y[COUNT_BITS-1:0];
        end
    end

    // A quotient above the coordinate range clamps to the coordinate maximum.
    assign cen_x = (|r_qx[SUM_BITS-1:COORD_BITS]) ? '1 : r_qx[COORD_BITS-1:0];
    assign cen_y = (|r_qy[SUM_BITS-1:COORD_BITS]) ? '1 : r_qy[COORD_BITS-1:0];

    always_comb begin
        if (cen_x > r_center_x && cen_y > r_center_y) begin
            move = MV_DOWN_RIGHT;
        end else if (cen_x > r_center_x && cen_y < r_center_y) begin
            move = MV_UP_RIGHT;
        end else if (cen_x < r_center_x && cen_y > r_center_y) begin
            move = MV_DOWN_LEFT;
        end else if (cen_x < r_center_x && cen_y < r_center_y) begin
            move = MV_UP_LEFT;
        end else begin
            move = MV_NONE;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pix) begin
            r_o_hue     <= hit ? pix_hue : '0;
            r_o_sat     <= hit ? pix_sat : '0;
            r_o_val     <= hit ? pix_val : '0;
            r_o_matched <= hit;
            r_o_done    <= 1'b0;
            r_o_cx      <= '0;
            r_o_cy      <= '0;
            r_o_move    <= MV_NONE;
        end else if (i_cmd.load_frame) begin
            r_o_hue     <= r_pend_hit ? r_pend_hue : '0;
            r_o_sat     <= r_pend_hit ? r_pend_sat : '0;
            r_o_val     <= r_pend_hit ? r_pend_val : '0;
            r_o_matched <= r_pend_hit;
            r_o_done    <= 1'b1;
            r_o_cx      <= cen_x;
            r_o_cy      <= cen_y;
            r_o_move    <= move;
        end
    end

    assign o_data = OUT_BITS'({r_o_move, r_o_cy, r_o_cx, r_o_val, r_o_sat, r_o_hue});
    assign o_matched    = r_o_matched;
    assign o_frame_done = r_o_done;

endmodule

@@ design/color_blob_centroid_tracker_unit.sv @@
// An ordinary pixel's result is registered on its transfer and is valid in the next cycle.
// Throughput: one ordinary pixel per cycle while the result side keeps up.
// On a frame-end pixel the bit-serial divider resolves one centroid bit per cycle
// on both axes at once; no new pixel is taken until the frame result is loaded.
// Reset (synchronous, active low) clears sums to 0, count to 1, loads the
// register defaults and clears output valid; the output data is not reset.
// ----------------------------------------------------------------------------
// Color blob centroid tracker
// HSV color window match with per-frame centroid and pan/tilt move code.
// ----------------------------------------------------------------------------
module color_blob_centroid_tracker_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cbct_pkg::IDX_BITS-1:0] i_cfg_idx,
    input  logic [cbct_pkg::CFG_BITS-1:0] i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // hue, sat, val, row, col (lowest bit up), zero padded
    input  logic [cbct_pkg::IN_BITS-1:0]  s_axis_tdata,
    input  logic                          s_axis_tlast,   // end_of_frame
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_hue, out_sat, out_val, centroid_x, centroid_y, move_code, zero padded
    output logic [cbct_pkg::OUT_BITS-1:0] m_axis_tdata,
    output logic                          m_axis_tuser,   // matched
    output logic                          m_axis_tlast    // frame_done
);
    import cbct_pkg::*;

    t_cmd cmd;

    cbct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    cbct_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_pix        (s_axis_tdata),
        .i_cmd        (cmd),
        .o_data       (m_axis_tdata),
        .o_matched    (m_axis_tuser),
        .o_frame_done (m_axis_tlast)
    );

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// Color blob centroid tracker testbench
// Streams HSV pixel frames through the tracker under several register
// settings, predicts every result in a scoreboard and checks each one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import cbct_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = SUM_BITS + 8;
    localparam longint unsigned SUM_MAX   = (64'd1 << SUM_BITS) - 1;
    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
    localparam longint unsigned COORD_MAX = (64'd1 << COORD_BITS) - 1;
    localparam int NUM_REGS = 8;

    typedef struct packed {
        logic [CHAN_BITS-1:0]  hue;
        logic [CHAN_BITS-1:0]  sat;
        logic [CHAN_BITS-1:0]  val;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
        logic                  eof;
    } t_pixel;

    typedef struct packed {
        logic [CHAN_BITS-1:0]  hue;
        logic [CHAN_BITS-1:0]  sat;
        logic [CHAN_BITS-1:0]  val;
        logic                  matched;
        logic                  frame_done;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [MOVE_BITS-1:0]  move;
    } t_result;

    class centroid_scoreboard;
        logic [CHAN_BITS-1:0]  hue_ref, sat_ref, val_ref;
        logic [CHAN_BITS-1:0]  hue_tol, sat_tol, val_tol;
        logic [COORD_BITS-1:0] center_x, center_y;
        longint unsigned row_sum, col_sum, match_count;
        t_result expected_q[$];
        int errors, n_pixels, n_frames, n_matched;
        int move_seen[5];

        function new();
            hue_ref = 0;
            sat_ref = 0;
            val_ref = 0;
            hue_tol = 20;
            sat_tol = 50;
            val_tol = 50;
            center_x = 160;
            center_y = 120;
            row_sum = 0;
            col_sum = 0;
            match_count = 1;
            errors = 0;
            n_pixels = 0;
            n_frames = 0;
            n_matched = 0;
            foreach (move_seen[i]) move_seen[i] = 0;
        endfunction

        function void write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
            case (idx)
                REG_HUE_REF:  hue_ref = data[CHAN_BITS-1:0];
                REG_SAT_REF:  sat_ref = data[CHAN_BITS-1:0];
                REG_VAL_REF:  val_ref = data[CHAN_BITS-1:0];
                REG_HUE_TOL:  hue_tol = data[CHAN_BITS-1:0];
                REG_SAT_TOL:  sat_tol = data[CHAN_BITS-1:0];
                REG_VAL_TOL:  val_tol = data[CHAN_BITS-1:0];
                REG_CENTER_X: center_x = data[COORD_BITS-1:0];
                REG_CENTER_Y: center_y = data[COORD_BITS-1:0];
                default: ;
            endcase
        endfunction

        // The window is signed, so it may extend below 0 or past 255.
        function bit in_window(int px, int ref_v, int tol);
            return px >= ref_v - tol && px <= ref_v + tol;
        endfunction

        function longint unsigned sat_add(longint unsigned a, longint unsigned b,
                                          longint unsigned maxv);
            longint unsigned s;
            s = a + b;
            return (s > maxv) ? maxv : s;
        endfunction

        function void note_pixel(t_pixel p);
            bit hit;
            longint unsigned cx, cy;
            logic [MOVE_BITS-1:0] mv;
            t_result r;
            hit = in_window(int'(p.hue), int'(hue_ref), int'(hue_tol)) &&
                  in_window(int'(p.sat), int'(sat_ref), int'(sat_tol)) &&
                  in_window(int'(p.val), int'(val_ref), int'(val_tol));
            cx = 0;
            cy = 0;
            mv = MV_NONE;
            if (hit) begin
                row_sum = sat_add(row_sum, longint'(p.row), SUM_MAX);
                col_sum = sat_add(col_sum, longint'(p.col), SUM_MAX);
                match_count = sat_add(match_count, 1, COUNT_MAX);
            end
            // The frame-end pixel is accumulated before the divide.
            if (p.eof) begin
                cx = col_sum / match_count;
                cy = row_sum / match_count;
                if (cx > COORD_MAX) cx = COORD_MAX;
                if (cy > COORD_MAX) cy = COORD_MAX;
                if (cx > center_x && cy > center_y) mv = MV_DOWN_RIGHT;
                else if (cx > center_x && cy < center_y) mv = MV_UP_RIGHT;
                else if (cx < center_x && cy > center_y) mv = MV_DOWN_LEFT;
                else if (cx < center_x && cy < center_y) mv = MV_UP_LEFT;
                row_sum = 0;
                col_sum = 0;
                match_count = 1;
                n_frames++;
                move_seen[mv]++;
            end
            r.hue = hit ? p.hue : '0;
            r.sat = hit ? p.sat : '0;
            r.val = hit ? p.val : '0;
            r.matched = hit;
            r.frame_done = p.eof;
            r.cx = cx[COORD_BITS-1:0];
            r.cy = cy[COORD_BITS-1:0];
            r.move = mv;
            n_pixels++;
            if (hit) n_matched++;
            expected_q.push_back(r);
        endfunction

        function string fmt(t_result r);
            return $sformatf("hsv=%0d/%0d/%0d match=%0d done=%0d cx=%0d cy=%0d move=%0d",
                             r.hue, r.sat, r.val, r.matched, r.frame_done,
                             r.cx, r.cy, r.move);
        endfunction

        function void check_result(t_result act);
            t_result exp_r;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("result with nothing expected: %s", fmt(act));
                return;
            end
            exp_r = expected_q.pop_front();
            if (act.hue !== exp_r.hue || act.sat !== exp_r.sat ||
                act.val !== exp_r.val || act.matched !== exp_r.matched ||
                act.frame_done !== exp_r.frame_done || act.cx !== exp_r.cx ||
                act.cy !== exp_r.cy || act.move !== exp_r.move) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: expected %s", fmt(exp_r));
                    $display("          actual   %s", fmt(act));
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [IDX_BITS-1:0]   i_cfg_idx = '0;
    logic [CFG_BITS-1:0]   i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_BITS-1:0]    s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0]   m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    centroid_scoreboard sb = new();
    logic [CFG_BITS-1:0] cfg_vals[NUM_REGS];
    bit idle_en = 1'b1;
    int cycles = 0;

    color_blob_centroid_tracker_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    function automatic t_pixel px(int h, int s, int v, int r, int c, bit e);
        t_pixel p;
        p.hue = h[CHAN_BITS-1:0];
        p.sat = s[CHAN_BITS-1:0];
        p.val = v[CHAN_BITS-1:0];
        p.row = r[COORD_BITS-1:0];
        p.col = c[COORD_BITS-1:0];
        p.eof = e;
        return p;
    endfunction

    // Most channel values land in or just around the window so that
    // frames actually collect matches.
    function automatic int near_chan(int ref_v, int tol);
        int v;
        if ($urandom_range(0, 9) < 6)
            v = ref_v + int'($urandom_range(0, 2 * tol + 4)) - tol - 2;
        else
            v = int'($urandom_range(0, 255));
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v;
    endfunction

    function automatic int rand_coord();
        if ($urandom_range(0, 9) < 8) return int'($urandom_range(0, COORD_MAX));
        return ($urandom_range(0, 1) != 0) ? int'(COORD_MAX) : 0;
    endfunction

    function automatic t_pixel rand_pixel(bit e);
        return px(near_chan(sb.hue_ref, sb.hue_tol), near_chan(sb.sat_ref, sb.sat_tol),
                  near_chan(sb.val_ref, sb.val_tol), rand_coord(), rand_coord(), e);
    endfunction

    task automatic send_pixel(t_pixel p);
        int gap;
        gap = idle_en ? int'($urandom_range(0, 6)) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_BITS'({p.col, p.row, p.val, p.sat, p.hue});
        s_axis_tlast  <= p.eof;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_pixel(p);
    endtask

    // Result side: with idle gaps enabled, holds ready low for a random gap before each transfer.
    initial begin
        int gap;
        t_result r;
        @(posedge i_rst_n);
        forever begin
            gap = idle_en ? int'($urandom_range(0, 6)) : 0;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            r.hue = m_axis_tdata[CHAN_BITS-1:0];
            r.sat = m_axis_tdata[2*CHAN_BITS-1:CHAN_BITS];
            r.val = m_axis_tdata[3*CHAN_BITS-1:2*CHAN_BITS];
            r.cx = m_axis_tdata[3*CHAN_BITS+COORD_BITS-1:3*CHAN_BITS];
            r.cy = m_axis_tdata[3*CHAN_BITS+2*COORD_BITS-1:3*CHAN_BITS+COORD_BITS];
            r.move = m_axis_tdata[OUT_RAW-1:3*CHAN_BITS+2*COORD_BITS];
            r.matched = m_axis_tuser;
            r.frame_done = m_axis_tlast;
            sb.check_result(r);
        end
    end

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic program_regs();
        for (int i = 0; i < NUM_REGS; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= i[IDX_BITS-1:0];
            i_cfg_data <= cfg_vals[i];
            @(posedge i_clk);
            sb.write_reg(i[IDX_BITS-1:0], cfg_vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_frames(int n_items);
        int left, flen;
        left = n_items;
        while (left > 0) begin
            flen = int'($urandom_range(1, 24));
            if (flen > left) flen = left;
            for (int j = 0; j < flen; j++) send_pixel(rand_pixel(j == flen - 1));
            left -= flen;
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register defaults: reference 0/0/0, tolerances 20/50/50, center 160/120.
        // One match at (240,320) plus the count's starting 1 lands exactly on center.
        send_pixel(px(0, 0, 0, 240, 320, 1'b1));
        // No match in the frame leaves the centroid at the origin.
        send_pixel(px(255, 255, 255, 1023, 1023, 1'b1));
        // Window edges, one channel out at a time.
        send_pixel(px(20, 50, 50, 0, 0, 1'b0));
        send_pixel(px(21, 50, 50, 1023, 1023, 1'b0));
        send_pixel(px(20, 51, 50, 1023, 1023, 1'b0));
        send_pixel(px(20, 50, 51, 1023, 1023, 1'b0));
        send_pixel(px(0, 0, 0, 1023, 1023, 1'b1));
        send_pixel(px(5, 5, 5, 1000, 1000, 1'b0));
        send_pixel(px(5, 5, 5, 0, 0, 1'b1));
        send_pixel(px(1, 2, 3, 0, 1000, 1'b1));
        send_pixel(px(3, 2, 1, 1000, 0, 1'b1));
        send_pixel(px(0, 0, 0, 1000, 320, 1'b1));
        send_pixel(px(0, 0, 0, 240, 0, 1'b1));
        send_pixel(px(200, 0, 0, 500, 500, 1'b1));
        drain();

        // Narrowest windows at the top of the channel range, center in the far corner.
        cfg_vals[REG_HUE_REF] = 255;
        cfg_vals[REG_SAT_REF] = 255;
        cfg_vals[REG_VAL_REF] = 255;
        cfg_vals[REG_HUE_TOL] = 0;
        cfg_vals[REG_SAT_TOL] = 0;
        cfg_vals[REG_VAL_TOL] = 0;
        cfg_vals[REG_CENTER_X] = COORD_MAX;
        cfg_vals[REG_CENTER_Y] = COORD_MAX;
        program_regs();
        send_pixel(px(255, 255, 255, 1023, 1023, 1'b0));
        send_pixel(px(254, 255, 255, 10, 10, 1'b0));
        send_pixel(px(255, 255, 255, 1023, 1023, 1'b1));
        run_frames(100);
        drain();

        // Widest windows, center at the origin.
        cfg_vals[REG_HUE_REF] = 0;
        cfg_vals[REG_SAT_REF] = 0;
        cfg_vals[REG_VAL_REF] = 0;
        cfg_vals[REG_HUE_TOL] = 255;
        cfg_vals[REG_SAT_TOL] = 255;
        cfg_vals[REG_VAL_TOL] = 255;
        cfg_vals[REG_CENTER_X] = 0;
        cfg_vals[REG_CENTER_Y] = 0;
        program_regs();
        idle_en = 1'b0;
        run_frames(100);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            cfg_vals[REG_HUE_REF] = {2'($urandom_range(0, 3)), 8'($urandom_range(0, 255))};
            cfg_vals[REG_SAT_REF] = {2'($urandom_range(0, 3)), 8'($urandom_range(0, 255))};
            cfg_vals[REG_VAL_REF] = {2'($urandom_range(0, 3)), 8'($urandom_range(0, 255))};
            cfg_vals[REG_HUE_TOL] = CFG_BITS'($urandom_range(0, 80));
            cfg_vals[REG_SAT_TOL] = CFG_BITS'($urandom_range(0, 80));
            cfg_vals[REG_VAL_TOL] = CFG_BITS'($urandom_range(0, 80));
            cfg_vals[REG_CENTER_X] = CFG_BITS'($urandom_range(0, COORD_MAX));
            cfg_vals[REG_CENTER_Y] = CFG_BITS'($urandom_range(0, COORD_MAX));
            program_regs();
            idle_en = (ph % 3 != 2);
            run_frames(110);
            drain();
        end

        $display("checked %0d pixels in %0d frames, %0d of them matched",
                 sb.n_pixels, sb.n_frames, sb.n_matched);
        $display("move codes none/dr/ur/dl/ul: %0d/%0d/%0d/%0d/%0d, mismatches %0d",
                 sb.move_seen[0], sb.move_seen[1], sb.move_seen[2],
                 sb.move_seen[3], sb.move_seen[4], sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
